>>> sv/fbpb_pkg.sv
package fbpb_pkg;

  localparam int MAX_BRUSH_SIZE_DEF = 400;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  localparam logic [CFG_IW-1:0] CFG_BRUSH_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BRUSH_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_FEATHER_Q12  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_OPACITY_Q16  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INVERT_MODE  = 3'd4;

  localparam logic [8:0]  BRUSH_SIZE_RST = 9'd100;
  localparam logic [15:0] FEATHER_MAX    = 16'd40960;
  localparam logic [16:0] ONE_Q16        = 17'h10000;
  localparam logic [14:0] RADIUS_Q16     = 15'd32113;
  localparam logic [30:0] RADIUS_SQ      = 31'd1031244769;
  localparam logic [7:0]  PIX_MAX        = 8'd255;
  localparam logic [23:0] WHITE_Q16      = 24'd16711680;

  localparam int AXIS_QW = 30;
  localparam int RAMP_DW = 31;
  localparam int RAMP_QW = 16;
  localparam int SQRT_IW = 30;
  localparam int SQRT_OW = 15;

  localparam int FBPB_LATENCY = 68;

  typedef struct packed {
    logic [16:0] op;
    logic        f_zero;
    logic [30:0] rf;
    logic        invert;
  } fbpb_cfg_t;

endpackage

>>> sv/fbpb_cfg_regs.sv
module fbpb_cfg_regs #(
  parameter int MAX_BRUSH_SIZE = fbpb_pkg::MAX_BRUSH_SIZE_DEF,
  parameter int GBW = $clog2(MAX_BRUSH_SIZE + 2)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fbpb_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [fbpb_pkg::CFG_DW-1:0]   cfg_data,
  output logic [GBW-1:0]                gw,
  output logic [GBW-1:0]                gh,
  output logic [2*GBW-1:0]              gw_sq,
  output logic [2*GBW-1:0]              gh_sq,
  output fbpb_pkg::fbpb_cfg_t           cfg
);
  import fbpb_pkg::*;

  logic [8:0]       brush_width_r;
  logic [8:0]       brush_height_r;
  logic [15:0]      feather_r;
  logic [16:0]      opacity_r;
  logic             invert_r;
  logic [2*GBW-1:0] gw_sq_r;
  logic [2*GBW-1:0] gh_sq_r;
  logic [30:0]      rf_r;
  logic [15:0]      feather_c;

  function automatic logic [GBW-1:0] grid_cells(input logic [8:0] size);
    logic [GBW-1:0] g;
    if (32'(size) > MAX_BRUSH_SIZE) begin
      g = GBW'(MAX_BRUSH_SIZE + 1);
    end else begin
      g = GBW'(size) + GBW'(1);
    end
    if (g < GBW'(2)) begin
      g = GBW'(2);
    end
    return g;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_width_r  <= BRUSH_SIZE_RST;
      brush_height_r <= BRUSH_SIZE_RST;
      feather_r      <= '0;
      opacity_r      <= ONE_Q16;
      invert_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BRUSH_WIDTH:  brush_width_r  <= cfg_data[8:0];
        CFG_BRUSH_HEIGHT: brush_height_r <= cfg_data[8:0];
        CFG_FEATHER_Q12:  feather_r      <= cfg_data[15:0];
        CFG_OPACITY_Q16:  opacity_r      <= cfg_data[16:0];
        CFG_INVERT_MODE:  invert_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign gw        = grid_cells(brush_width_r);
  assign gh        = grid_cells(brush_height_r);
  assign feather_c = (feather_r > FEATHER_MAX) ? FEATHER_MAX : feather_r;

  always_ff @(posedge clk) begin
    gw_sq_r <= gw * gw;
    gh_sq_r <= gh * gh;
    rf_r    <= RADIUS_Q16 * feather_c;
  end

  assign gw_sq      = gw_sq_r;
  assign gh_sq      = gh_sq_r;
  assign cfg.op     = (opacity_r > ONE_Q16) ? ONE_Q16 : opacity_r;
  assign cfg.f_zero = (feather_r == 16'd0);
  assign cfg.rf     = rf_r;
  assign cfg.invert = invert_r;

endmodule

>>> sv/fbpb_div_pipe.sv
module fbpb_div_pipe #(
  parameter int DW = 31,
  parameter int QW = 16,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_lo,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] in_payload,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_payload
);

  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] lo_r    [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [PW-1:0] pay_r   [QW];
  logic          vld_r   [QW];

  logic [DW-1:0] rem_p   [QW];
  logic [QW-1:0] lo_p    [QW];
  logic [QW-1:0] quo_p   [QW];
  logic [PW-1:0] pay_p   [QW];
  logic          vld_p   [QW];

  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  always_comb begin
    rem_p[0] = in_rem;
    lo_p[0]  = in_lo;
    quo_p[0] = '0;
    pay_p[0] = in_payload;
    vld_p[0] = in_valid;
    for (int i = 1; i < QW; i++) begin
      rem_p[i] = rem_r[i-1];
      lo_p[i]  = lo_r[i-1];
      quo_p[i] = quo_r[i-1];
      pay_p[i] = pay_r[i-1];
      vld_p[i] = vld_r[i-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic        take;
    for (int i = 0; i < QW; i++) begin
      trial = {rem_p[i], lo_p[i][QW-1]};
      take  = (trial >= {1'b0, divisor});
      rem_nxt[i] = take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      quo_nxt[i] = {quo_p[i][QW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW; i++) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_p[i];
      end
      rem_r[i] <= rem_nxt[i];
      lo_r[i]  <= {lo_p[i][QW-2:0], 1'b0};
      quo_r[i] <= quo_nxt[i];
      pay_r[i] <= pay_p[i];
    end
  end

  assign out_valid   = vld_r[QW-1];
  assign out_quo     = quo_r[QW-1];
  assign out_payload = pay_r[QW-1];

endmodule

>>> sv/fbpb_sqrt_pipe.sv
module fbpb_sqrt_pipe #(
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [fbpb_pkg::SQRT_IW-1:0]  in_n,
  input  logic [PW-1:0]                 in_payload,
  output logic                          out_valid,
  output logic [fbpb_pkg::SQRT_OW-1:0]  out_root,
  output logic [PW-1:0]                 out_payload
);
  import fbpb_pkg::*;

  logic [SQRT_IW-1:0] n_r     [SQRT_OW];
  logic [SQRT_IW-1:0] res_r   [SQRT_OW];
  logic [PW-1:0]      pay_r   [SQRT_OW];
  logic               vld_r   [SQRT_OW];

  logic [SQRT_IW-1:0] n_p     [SQRT_OW];
  logic [SQRT_IW-1:0] res_p   [SQRT_OW];
  logic [PW-1:0]      pay_p   [SQRT_OW];
  logic               vld_p   [SQRT_OW];

  logic [SQRT_IW-1:0] n_nxt   [SQRT_OW];
  logic [SQRT_IW-1:0] res_nxt [SQRT_OW];

  always_comb begin
    n_p[0]   = in_n;
    res_p[0] = '0;
    pay_p[0] = in_payload;
    vld_p[0] = in_valid;
    for (int i = 1; i < SQRT_OW; i++) begin
      n_p[i]   = n_r[i-1];
      res_p[i] = res_r[i-1];
      pay_p[i] = pay_r[i-1];
      vld_p[i] = vld_r[i-1];
    end
  end

  always_comb begin
    logic [SQRT_IW-1:0] bitv;
    logic [SQRT_IW:0]   trial;
    logic               take;
    for (int i = 0; i < SQRT_OW; i++) begin
      bitv  = SQRT_IW'(1) << (2 * (SQRT_OW - 1 - i));
      trial = {1'b0, res_p[i]} + {1'b0, bitv};
      take  = ({1'b0, n_p[i]} >= trial);
      n_nxt[i]   = take ? SQRT_IW'({1'b0, n_p[i]} - trial) : n_p[i];
      res_nxt[i] = take ? (res_p[i] >> 1) + bitv : (res_p[i] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQRT_OW; i++) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_p[i];
      end
      n_r[i]   <= n_nxt[i];
      res_r[i] <= res_nxt[i];
      pay_r[i] <= pay_p[i];
    end
  end

  assign out_valid   = vld_r[SQRT_OW-1];
  assign out_root    = res_r[SQRT_OW-1][SQRT_OW-1:0];
  assign out_payload = pay_r[SQRT_OW-1];

endmodule

>>> sv/feathered_brush_pixel_blend.sv
// Feathered round brush stamp, one blend-mask pixel per clock.
// Input: raise start with in_pixel_in and its footprint column and row
// (in_brush_x, in_brush_y); the pixel is taken at that edge when busy is low.
// busy is high only while rst_n is low, so a pixel can be taken every cycle.
// Output: out_valid pulses for one cycle with out_pixel_out; results leave in
// the order the pixels came in, and the receiver cannot hold them off.
// Throughput is one pixel per cycle. The depth is set by the two
// axis dividers (30 quotient bits, one per stage), the square root (15 root
// bits, one per stage) and the ramp divider (16 quotient bits, one per
// stage), plus seven stages of offset, square, sum, multiply and blend.
// Configuration: cfg_we writes cfg_data into register cfg_index (brush width,
// brush height, feather, opacity, invert mode); write only with no pixel in
// flight. Reset empties the pipeline and loads width and height 100,
// feather 0, opacity one and normal mode, with no clearing pass.
module feathered_brush_pixel_blend #(
  parameter int MAX_BRUSH_SIZE = fbpb_pkg::MAX_BRUSH_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  in_pixel_in,
  input  logic [8:0]                  in_brush_x,
  input  logic [8:0]                  in_brush_y,
  output logic                        out_valid,
  output logic [7:0]                  out_pixel_out,
  input  logic                        cfg_we,
  input  logic [fbpb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fbpb_pkg::CFG_DW-1:0] cfg_data
);
  import fbpb_pkg::*;

  localparam int GBW = $clog2(MAX_BRUSH_SIZE + 2);
  localparam int NW  = (GBW > 10) ? GBW : 10;

  logic [GBW-1:0]     gw;
  logic [GBW-1:0]     gh;
  logic [2*GBW-1:0]   gw_sq;
  logic [2*GBW-1:0]   gh_sq;
  fbpb_cfg_t          cfg;

  logic               accept;
  logic               s1_vld_r;
  logic [7:0]         s1_pix_r;
  logic [GBW:0]       s1_offx_r;
  logic [GBW:0]       s1_offy_r;

  logic               s2_vld_r;
  logic [7:0]         s2_pix_r;
  logic [2*GBW-1:0]   s2_sqx_r;
  logic [2*GBW-1:0]   s2_sqy_r;
  logic               s2_farx_r;
  logic               s2_fary_r;

  logic               dx_vld;
  logic [AXIS_QW-1:0] dx_quo;
  logic [8:0]         dx_pay;
  logic               dy_vld;
  logic [AXIS_QW-1:0] dy_quo;
  logic               dy_far;

  logic [30:0]        sum_c;
  logic               inside_c;
  logic               s3_vld_r;
  logic [7:0]         s3_pix_r;
  logic               s3_inside_r;
  logic [SQRT_IW-1:0] s3_n_r;

  logic               sq_vld;
  logic [SQRT_OW-1:0] sq_d;
  logic [8:0]         sq_pay;

  logic [14:0]        diff_c;
  logic               s4_vld_r;
  logic [7:0]         s4_pix_r;
  logic               s4_inside_r;
  logic [31:0]        s4_m_r;
  logic               ovf_c;

  logic               rd_vld;
  logic [RAMP_QW-1:0] rd_quo;
  logic [9:0]         rd_pay;

  logic [16:0]        v_c;
  logic               s5_vld_r;
  logic [7:0]         s5_pix_r;
  logic [16:0]        s5_v_r;

  logic [7:0]         a_c;
  logic               s6_vld_r;
  logic [24:0]        s6_prod_r;

  logic [24:0]        white_diff_c;
  logic [7:0]         out_pixel_nxt;
  logic               out_valid_r;
  logic [7:0]         out_pixel_r;

  function automatic logic [GBW:0] axis_offset(input logic [8:0] c,
                                               input logic [GBW-1:0] g);
    logic [NW-1:0] two_c;
    logic [NW-1:0] g_e;
    logic [NW-1:0] d;
    two_c = NW'({c, 1'b0});
    g_e   = NW'(g);
    d     = (two_c >= g_e) ? two_c - g_e : g_e - two_c;
    return {(d >= g_e), d[GBW-1:0]};
  endfunction

  fbpb_cfg_regs #(
    .MAX_BRUSH_SIZE (MAX_BRUSH_SIZE),
    .GBW            (GBW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gw        (gw),
    .gh        (gh),
    .gw_sq     (gw_sq),
    .gh_sq     (gh_sq),
    .cfg       (cfg)
  );

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // doubled offset from grid center, far flag when it reaches the grid size, then its square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
    s1_pix_r  <= in_pixel_in;
    s1_offx_r <= axis_offset(in_brush_x, gw);
    s1_offy_r <= axis_offset(in_brush_y, gh);
    s2_pix_r  <= s1_pix_r;
    s2_sqx_r  <= s1_offx_r[GBW-1:0] * s1_offx_r[GBW-1:0];
    s2_sqy_r  <= s1_offy_r[GBW-1:0] * s1_offy_r[GBW-1:0];
    s2_farx_r <= s1_offx_r[GBW];
    s2_fary_r <= s1_offy_r[GBW];
  end

  fbpb_div_pipe #(
    .DW (2 * GBW),
    .QW (AXIS_QW),
    .PW (9)
  ) u_div_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s2_vld_r),
    .in_rem      (s2_sqx_r),
    .in_lo       ('0),
    .divisor     (gw_sq),
    .in_payload  ({s2_pix_r, s2_farx_r}),
    .out_valid   (dx_vld),
    .out_quo     (dx_quo),
    .out_payload (dx_pay)
  );

  fbpb_div_pipe #(
    .DW (2 * GBW),
    .QW (AXIS_QW),
    .PW (1)
  ) u_div_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s2_vld_r),
    .in_rem      (s2_sqy_r),
    .in_lo       ('0),
    .divisor     (gh_sq),
    .in_payload  (s2_fary_r),
    .out_valid   (dy_vld),
    .out_quo     (dy_quo),
    .out_payload (dy_far)
  );

  assign sum_c    = 31'(dx_quo) + 31'(dy_quo);
  assign inside_c = ~dx_pay[0] & ~dy_far & (sum_c < RADIUS_SQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= dx_vld & dy_vld;
    end
    s3_pix_r    <= dx_pay[8:1];
    s3_inside_r <= inside_c;
    s3_n_r      <= inside_c ? sum_c[SQRT_IW-1:0] : '0;
  end

  fbpb_sqrt_pipe #(
    .PW (9)
  ) u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s3_vld_r),
    .in_n        (s3_n_r),
    .in_payload  ({s3_pix_r, s3_inside_r}),
    .out_valid   (sq_vld),
    .out_root    (sq_d),
    .out_payload (sq_pay)
  );

  assign diff_c = RADIUS_Q16 - sq_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= sq_vld;
    end
    s4_pix_r    <= sq_pay[8:1];
    s4_inside_r <= sq_pay[0];
    s4_m_r      <= cfg.op * diff_c;
  end

  // ramp saturates once op*(R-d) reaches 16*R*f
  assign ovf_c = ({3'b000, s4_m_r[31:4]} >= cfg.rf);

  fbpb_div_pipe #(
    .DW (RAMP_DW),
    .QW (RAMP_QW),
    .PW (10)
  ) u_div_ramp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s4_vld_r),
    .in_rem      (RAMP_DW'(s4_m_r[31:4])),
    .in_lo       ({s4_m_r[3:0], 12'h000}),
    .divisor     (cfg.rf),
    .in_payload  ({s4_pix_r, s4_inside_r, ovf_c}),
    .out_valid   (rd_vld),
    .out_quo     (rd_quo),
    .out_payload (rd_pay)
  );

  always_comb begin
    if (!rd_pay[1]) begin
      v_c = ONE_Q16;
    end else if (cfg.f_zero) begin
      v_c = ONE_Q16 - cfg.op;
    end else if (rd_pay[0]) begin
      v_c = '0;
    end else begin
      v_c = ONE_Q16 - {1'b0, rd_quo};
    end
  end

  assign a_c = cfg.invert ? s5_pix_r : PIX_MAX - s5_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= rd_vld;
      s6_vld_r <= s5_vld_r;
    end
    s5_pix_r  <= rd_pay[9:2];
    s5_v_r    <= v_c;
    s6_prod_r <= a_c * s5_v_r;
  end

  assign white_diff_c  = {1'b0, WHITE_Q16} - s6_prod_r;
  assign out_pixel_nxt = cfg.invert ? s6_prod_r[23:16] : white_diff_c[23:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s6_vld_r;
    end
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

>>> sv/fbpb_checker.sv
module fbpb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [7:0]                  in_pixel_in,
  input logic                        out_valid,
  input logic [7:0]                  out_pixel_out,
  input logic                        cfg_we,
  input logic [fbpb_pkg::CFG_IW-1:0] cfg_index,
  input logic [fbpb_pkg::CFG_DW-1:0] cfg_data
);
  import fbpb_pkg::*;

  logic accept;
  logic invert_r;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_INVERT_MODE)) begin
      invert_r <= cfg_data[0];
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##FBPB_LATENCY out_valid)
    else $error("transaction did not produce a result at the expected latency");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, FBPB_LATENCY))
    else $error("result without a matching input transaction");

  a_normal_brightens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !invert_r) |-> (out_pixel_out >= $past(in_pixel_in, FBPB_LATENCY)))
    else $error("normal mode result darker than its input pixel");

  a_invert_darkens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && invert_r) |-> (out_pixel_out <= $past(in_pixel_in, FBPB_LATENCY)))
    else $error("inverted mode result brighter than its input pixel");

endmodule

bind feathered_brush_pixel_blend fbpb_checker u_fbpb_checker (.*);

>>> tb/sv/fbpb_blend_checker.sv
`timescale 1ns / 1ps
module fbpb_blend_checker #(
  parameter int MAX_BRUSH_SIZE = fbpb_pkg::MAX_BRUSH_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [7:0]                  in_pixel_in,
  input  logic [8:0]                  in_brush_x,
  input  logic [8:0]                  in_brush_y,
  input  logic                        out_valid,
  input  logic [7:0]                  out_pixel_out,
  input  logic                        cfg_we,
  input  logic [fbpb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fbpb_pkg::CFG_DW-1:0] cfg_data,
  output int                          mismatches,
  output int                          pending,
  output int                          checked
);
  import fbpb_pkg::*;

  typedef struct packed {
    logic [7:0] pix_in;
    logic [8:0] col;
    logic [8:0] row;
    logic [7:0] stamped;
  } stamp_t;

  logic [8:0]  width_r;
  logic [8:0]  height_r;
  logic [15:0] feather_r;
  logic [16:0] opacity_r;
  logic        invert_r;

  stamp_t expected_stamps[$];
  int     mismatch_count = 0;
  int     checked_count  = 0;
  int     pending_count  = 0;

  assign mismatches = mismatch_count;
  assign pending    = pending_count;
  assign checked    = checked_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic longint unsigned axis_offset_sq(logic [8:0] c, logic [8:0] size);
    longint unsigned g, twoc, num, den;
    g = size;
    if (g > MAX_BRUSH_SIZE) g = MAX_BRUSH_SIZE;
    g = g + 1;
    if (g < 2) g = 2;
    twoc = c;
    twoc = twoc * 2;
    num = (twoc >= g) ? twoc - g : g - twoc;
    den = 2 * g;
    return ((num * num) << 32) / (den * den);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [7:0] stamped_pixel(logic [7:0] p, logic [8:0] x, logic [8:0] y);
    longint unsigned radial_d, op, f, s, v, pix, r;
    radial_d = floor_root(axis_offset_sq(x, width_r) + axis_offset_sq(y, height_r));
    op   = (opacity_r > ONE_Q16) ? ONE_Q16 : opacity_r;
    f    = (feather_r > FEATHER_MAX) ? FEATHER_MAX : feather_r;
    pix  = p;
    if (radial_d >= RADIUS_Q16) begin
      v = ONE_Q16;
    end else begin
      if (f == 0) s = op;
      else s = ((op * (RADIUS_Q16 - radial_d)) << 12) / (RADIUS_Q16 * f);
      v = (s >= ONE_Q16) ? 0 : ONE_Q16 - s;
    end
    if (invert_r) r = (pix * v) >> 16;
    else r = (WHITE_Q16 - (PIX_MAX - pix) * v) >> 16;
    return r[7:0];
  endfunction

  always @(posedge clk) begin
    stamp_t got;
    stamp_t exp;
    if (!rst_n) begin
      width_r   <= BRUSH_SIZE_RST;
      height_r  <= BRUSH_SIZE_RST;
      feather_r <= '0;
      opacity_r <= ONE_Q16;
      invert_r  <= 1'b0;
      expected_stamps.delete();
      pending_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_stamps.size() == 0) begin
          report_mismatch($sformatf("result %0d with no pixel in flight", out_pixel_out));
        end else begin
          exp = expected_stamps.pop_front();
          checked_count++;
          if (out_pixel_out !== exp.stamped)
            report_mismatch($sformatf("pixel %0d at (%0d,%0d): got %0d, want %0d",
                                      exp.pix_in, exp.col, exp.row, out_pixel_out,
                                      exp.stamped));
        end
      end
      if (start && !busy) begin
        got.pix_in  = in_pixel_in;
        got.col     = in_brush_x;
        got.row     = in_brush_y;
        got.stamped = stamped_pixel(in_pixel_in, in_brush_x, in_brush_y);
        expected_stamps.push_back(got);
      end
      pending_count = expected_stamps.size();
      if (cfg_we) begin
        case (cfg_index)
          CFG_BRUSH_WIDTH:  width_r   <= cfg_data[8:0];
          CFG_BRUSH_HEIGHT: height_r  <= cfg_data[8:0];
          CFG_FEATHER_Q12:  feather_r <= cfg_data[15:0];
          CFG_OPACITY_Q16:  opacity_r <= cfg_data[16:0];
          CFG_INVERT_MODE:  invert_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import fbpb_pkg::*;

  localparam int RANDOM_PER_PHASE = 139;
  localparam int NUM_PHASES       = 11;
  localparam int CYCLE_LIMIT      = 200000;
  localparam logic [CFG_IW-1:0] CFG_SPARE_FIRST = CFG_INVERT_MODE + 3'd1;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [7:0]        in_pixel_in = '0;
  logic [8:0]        in_brush_x  = '0;
  logic [8:0]        in_brush_y  = '0;
  logic              out_valid;
  logic [7:0]        out_pixel_out;
  logic              cfg_we      = 1'b0;
  logic [CFG_IW-1:0] cfg_index   = '0;
  logic [CFG_DW-1:0] cfg_data    = '0;

  int   mismatches;
  int   pending;
  int   checked;
  int   cycles   = 0;
  int   sent     = 0;
  int   settings = 1;
  bit   idle_on  = 1'b1;
  logic [8:0] cur_w = BRUSH_SIZE_RST;
  logic [8:0] cur_h = BRUSH_SIZE_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  feathered_brush_pixel_blend dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_in(in_pixel_in), .in_brush_x(in_brush_x), .in_brush_y(in_brush_y),
    .out_valid(out_valid), .out_pixel_out(out_pixel_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fbpb_blend_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_in(in_pixel_in), .in_brush_x(in_brush_x), .in_brush_y(in_brush_y),
    .out_valid(out_valid), .out_pixel_out(out_pixel_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("feathered_brush_pixel_blend regression: fail");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] p, input logic [8:0] x, input logic [8:0] y);
    int gap;
    @(negedge clk);
    start       = 1'b1;
    in_pixel_in = p;
    in_brush_x  = x;
    in_brush_y  = y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_BRUSH_WIDTH) cur_w = data[8:0];
    if (idx == CFG_BRUSH_HEIGHT) cur_h = data[8:0];
  endtask

  task automatic configure(input int ph);
    logic [CFG_DW-1:0] w, h, f, op, inv;
    case (ph)
      1: begin
        w = 30; h = 30; f = 0; op = 65536; inv = 0;
      end
      2: begin
        w = 400; h = 400; f = 40960; op = 65536; inv = 1;
      end
      3: begin
        w = 0; h = 1; f = 4096; op = 0; inv = 0;
      end
      4: begin
        w = 17'h1FFFF; h = 511; f = 65535; op = 17'h1FFFF; inv = 17'h1FFFF;
      end
      5: begin
        w = 400; h = 30; f = 1; op = 1; inv = 0;
      end
      default: begin
        w   = CFG_DW'($urandom_range(30, 400));
        h   = CFG_DW'($urandom_range(30, 400));
        f   = CFG_DW'(($urandom_range(0, 5) == 0) ? $urandom_range(40961, 65535)
                                                  : $urandom_range(0, 40960));
        op  = CFG_DW'(($urandom_range(0, 5) == 0) ? $urandom_range(65537, 131071)
                                                  : $urandom_range(0, 65536));
        inv = CFG_DW'($urandom_range(0, 1));
      end
    endcase
    write_reg(CFG_BRUSH_WIDTH, w);
    write_reg(CFG_BRUSH_HEIGHT, h);
    write_reg(CFG_FEATHER_Q12, f);
    write_reg(CFG_OPACITY_Q16, op);
    write_reg(CFG_INVERT_MODE, inv);
    // drop: writes past the last register must change nothing
    write_reg(CFG_SPARE_FIRST + 3'($urandom_range(0, 2)), CFG_DW'($urandom));
    settings++;
  endtask

  task automatic random_pixel();
    logic [7:0] p;
    logic [8:0] x, y;
    int xmax, ymax;
    xmax = (cur_w + 1 > 511) ? 511 : cur_w + 1;
    ymax = (cur_h + 1 > 511) ? 511 : cur_h + 1;
    case ($urandom_range(0, 9))
      0:       p = 8'd0;
      1:       p = 8'd255;
      default: p = 8'($urandom_range(0, 255));
    endcase
    x = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, xmax));
    y = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, ymax));
    push_pixel(p, x, y);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: 101-cell grid, hard edge, full opacity
    push_pixel(8'd0,   9'd50,  9'd50);
    push_pixel(8'd255, 9'd50,  9'd50);
    push_pixel(8'd128, 9'd51,  9'd51);
    push_pixel(8'd0,   9'd0,   9'd0);
    push_pixel(8'd255, 9'd100, 9'd100);
    push_pixel(8'd77,  9'd101, 9'd50);
    push_pixel(8'd77,  9'd50,  9'd1);
    push_pixel(8'd77,  9'd1,   9'd50);
    push_pixel(8'd77,  9'd100, 9'd50);
    push_pixel(8'd77,  9'd2,   9'd50);
    push_pixel(8'd200, 9'd15,  9'd15);
    push_pixel(8'd200, 9'd16,  9'd16);
    push_pixel(8'd1,   9'd511, 9'd511);
    push_pixel(8'd254, 9'd0,   9'd511);
    push_pixel(8'd170, 9'd511, 9'd0);
    push_pixel(8'd85,  9'h155, 9'h0AA);
    push_pixel(8'd170, 9'h0AA, 9'h155);
    push_pixel(8'd0,   9'd256, 9'd256);
    push_pixel(8'd255, 9'd25,  9'd75);

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain();
      configure(ph);
      if (ph == NUM_PHASES) idle_on = 1'b0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_pixel();
    end

    drain();
    repeat (FBPB_LATENCY + 8) @(negedge clk);
    $display("stamped %0d pixels over %0d register settings, %0d results compared",
             sent, settings, checked);
    $display("%0d mismatches, %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("feathered_brush_pixel_blend regression: pass");
    end else begin
      $display("feathered_brush_pixel_blend regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/fbpb_pkg.sv
sv/fbpb_cfg_regs.sv
sv/fbpb_div_pipe.sv
sv/fbpb_sqrt_pipe.sv
sv/feathered_brush_pixel_blend.sv
sv/fbpb_checker.sv
tb/sv/fbpb_blend_checker.sv
tb/sv/tb.sv
